// ----- hw/rtl/scta_pkg.sv -----
// Shared types, operation codes and the scan-code-set-1 key table for the
// scancode-to-ASCII line buffer. No dependencies.
package scta_pkg;

  // Default sizes of the line buffer.
  localparam int BufDepthDefault = 32;
  localparam int TabSpacesDefault = 8;

  // Scan codes with special handling.
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3a;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
  localparam logic [7:0] SC_BACKSPACE    = 8'h0e;
  localparam logic [7:0] SC_TAB          = 8'h0f;
  localparam logic [7:0] SC_ENTER        = 8'h1c;
  localparam logic [7:0] SC_SPACE        = 8'h39;

  // Characters stored for the special keys.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // Operation classes of one scan code.
  localparam logic [2:0] KIND_IGNORE = 3'd0;
  localparam logic [2:0] KIND_SHIFT  = 3'd1;
  localparam logic [2:0] KIND_BKSP   = 3'd2;
  localparam logic [2:0] KIND_TAB    = 3'd3;
  localparam logic [2:0] KIND_ENTER  = 3'd4;
  localparam logic [2:0] KIND_SPACE  = 3'd5;
  localparam logic [2:0] KIND_KEY    = 3'd6;

  // Decoded form of one scan code.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
  } key_info_t;

  // Result of a table lookup: hit flag and character.
  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } key_hit_t;

  // Looks up one of the 47 table keys; the shift flag picks the column.
  function automatic key_hit_t key_lookup(input logic [7:0] code, input logic shift);
    key_hit_t r;
    logic [7:0] lo;
    logic [7:0] up;
    r.hit = 1'b1;
    lo = 8'h00;
    up = 8'h00;
    unique case (code)
      8'h1e: begin lo = 8'h61; up = 8'h41; end
      8'h30: begin lo = 8'h62; up = 8'h42; end
      8'h2e: begin lo = 8'h63; up = 8'h43; end
      8'h20: begin lo = 8'h64; up = 8'h44; end
      8'h12: begin lo = 8'h65; up = 8'h45; end
      8'h21: begin lo = 8'h66; up = 8'h46; end
      8'h22: begin lo = 8'h67; up = 8'h47; end
      8'h23: begin lo = 8'h68; up = 8'h48; end
      8'h17: begin lo = 8'h69; up = 8'h49; end
      8'h24: begin lo = 8'h6a; up = 8'h4a; end
      8'h25: begin lo = 8'h6b; up = 8'h4b; end
      8'h26: begin lo = 8'h6c; up = 8'h4c; end
      8'h32: begin lo = 8'h6d; up = 8'h4d; end
      8'h31: begin lo = 8'h6e; up = 8'h4e; end
      8'h18: begin lo = 8'h6f; up = 8'h4f; end
      8'h19: begin lo = 8'h70; up = 8'h50; end
      8'h10: begin lo = 8'h71; up = 8'h51; end
      8'h13: begin lo = 8'h72; up = 8'h52; end
      8'h1f: begin lo = 8'h73; up = 8'h53; end
      8'h14: begin lo = 8'h74; up = 8'h54; end
      8'h16: begin lo = 8'h75; up = 8'h55; end
      8'h2f: begin lo = 8'h76; up = 8'h56; end
      8'h11: begin lo = 8'h77; up = 8'h57; end
      8'h2d: begin lo = 8'h78; up = 8'h58; end
      8'h15: begin lo = 8'h79; up = 8'h59; end
      8'h2c: begin lo = 8'h7a; up = 8'h5a; end
      8'h29: begin lo = 8'h60; up = 8'h7e; end
      8'h02: begin lo = 8'h31; up = 8'h21; end
      8'h03: begin lo = 8'h32; up = 8'h40; end
      8'h04: begin lo = 8'h33; up = 8'h23; end
      8'h05: begin lo = 8'h34; up = 8'h24; end
      8'h06: begin lo = 8'h35; up = 8'h25; end
      8'h07: begin lo = 8'h36; up = 8'h5e; end
      8'h08: begin lo = 8'h37; up = 8'h26; end
      8'h09: begin lo = 8'h38; up = 8'h2a; end
      8'h0a: begin lo = 8'h39; up = 8'h28; end
      8'h0b: begin lo = 8'h30; up = 8'h29; end
      8'h0c: begin lo = 8'h2d; up = 8'h5f; end
      8'h0d: begin lo = 8'h3d; up = 8'h2b; end
      8'h1a: begin lo = 8'h5b; up = 8'h7b; end
      8'h1b: begin lo = 8'h5d; up = 8'h7d; end
      8'h27: begin lo = 8'h3b; up = 8'h3a; end
      8'h28: begin lo = 8'h27; up = 8'h22; end
      8'h2b: begin lo = 8'h5c; up = 8'h7c; end
      8'h33: begin lo = 8'h2c; up = 8'h3c; end
      8'h34: begin lo = 8'h2e; up = 8'h3e; end
      8'h35: begin lo = 8'h2f; up = 8'h3f; end
      default: r.hit = 1'b0;
    endcase
    r.ch = shift ? up : lo;
    return r;
  endfunction

endpackage

// ----- hw/rtl/scta_decode.sv -----
// Classifies one scan-code-set-1 byte and picks the character it stores.
// Depends on scta_pkg for the operation codes and the key table.
module scta_decode (
  input  logic [7:0]         scan_code,
  input  logic               shift,
  output scta_pkg::key_info_t info
);

  scta_pkg::key_hit_t hit;

  assign hit = scta_pkg::key_lookup(scan_code, shift);

  // Special keys first; anything else goes through the key table.
  always_comb begin
    info.kind = scta_pkg::KIND_IGNORE;
    info.ch   = 8'h00;
    priority if (scan_code == scta_pkg::SC_CAPS_MAKE ||
                 scan_code == scta_pkg::SC_LSHIFT_MAKE ||
                 scan_code == scta_pkg::SC_RSHIFT_MAKE ||
                 scan_code == scta_pkg::SC_LSHIFT_BREAK ||
                 scan_code == scta_pkg::SC_RSHIFT_BREAK) begin
      info.kind = scta_pkg::KIND_SHIFT;
    end else if (scan_code == scta_pkg::SC_BACKSPACE) begin
      info.kind = scta_pkg::KIND_BKSP;
    end else if (scan_code == scta_pkg::SC_TAB) begin
      info.kind = scta_pkg::KIND_TAB;
      info.ch   = scta_pkg::CH_SPACE;
    end else if (scan_code == scta_pkg::SC_ENTER) begin
      info.kind = scta_pkg::KIND_ENTER;
      info.ch   = scta_pkg::CH_CR;
    end else if (scan_code == scta_pkg::SC_SPACE) begin
      info.kind = scta_pkg::KIND_SPACE;
      info.ch   = scta_pkg::CH_SPACE;
    end else if (hit.hit) begin
      info.kind = scta_pkg::KIND_KEY;
      info.ch   = hit.ch;
    end else begin
      info.kind = scta_pkg::KIND_IGNORE;
    end
  end

endmodule

// ----- hw/rtl/scancode_to_ascii_line_buffer_core.sv -----
// Top level of the scancode-to-ASCII line buffer: control, ring memory, output register.
// Depends on scta_pkg and scta_decode.

// Takes one transaction at a time, each either a set-1 scan code byte (func = 0) or a
// request to read one buffered character (func = 1), and returns exactly one result
// transaction for it. Characters live in a BUF_DEPTH-entry ring memory with a
// registered read; a valid bit per entry makes never-written entries read as zero, so
// no clearing pass is needed after reset. Reads, shift, backspace and ignored codes go
// straight to the finish state; space, enter and table keys pass through the write state
// first, and tab stays in it for TAB_SPACES writes, one character per cycle through the
// single memory write port. cmd_ready returns in the cycle after the result is
// loaded; a new transaction may be accepted while the previous result waits on
// res_ready, and its own result is held until the output register frees up.
module scancode_to_ascii_line_buffer_core #(
  parameter int BUF_DEPTH  = scta_pkg::BufDepthDefault,
  parameter int TAB_SPACES = scta_pkg::TabSpacesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic       func,
  input  logic [7:0] scan_code,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] read_char,
  output logic       line_done,
  output logic [5:0] fill_count,
  output logic       shift_on
);

  localparam int IW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int TW = $clog2(TAB_SPACES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(BUF_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(BUF_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WRITE  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]    state;
  logic          shift_flag;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic [TW-1:0] remain;
  logic          op_read;
  logic [2:0]    op_kind;
  logic [7:0]    op_ch;
  logic [BUF_DEPTH-1:0] entry_valid;
  logic          rd_hit;
  logic [7:0]    rdata;
  logic [7:0]    mem [BUF_DEPTH];

  scta_pkg::key_info_t dec;
  logic accept;
  logic mem_we;
  logic mem_re;
  logic res_load;
  logic [IW-1:0] wr_idx_inc;
  logic [IW-1:0] wr_idx_dec;
  logic [IW-1:0] rd_idx_inc;

  scta_decode u_decode (
    .scan_code (scan_code),
    .shift     (shift_flag),
    .info      (dec)
  );

  assign cmd_ready  = (state == ST_IDLE);
  assign accept     = cmd_valid && cmd_ready;
  assign mem_re     = accept && func;
  assign mem_we     = (state == ST_WRITE);
  assign res_load   = (state == ST_FINISH) && (!res_valid || res_ready);
  assign wr_idx_inc = (wr_idx == LastIdx) ? '0 : wr_idx + 1'b1;
  assign wr_idx_dec = (wr_idx == '0) ? LastIdx : wr_idx - 1'b1;
  assign rd_idx_inc = (rd_idx == LastIdx) ? '0 : rd_idx + 1'b1;

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= op_ch;
    end
    if (mem_re) begin
      rdata <= mem[rd_idx];
    end
  end

  // Operation registers captured at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_read <= func;
      op_kind <= dec.kind;
      op_ch   <= dec.ch;
    end
  end

  // Sequencer and buffer bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      shift_flag  <= 1'b0;
      wr_idx      <= '0;
      rd_idx      <= '0;
      count       <= '0;
      remain      <= '0;
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (func) begin
              rd_hit <= entry_valid[rd_idx];
              rd_idx <= rd_idx_inc;
              state  <= ST_FINISH;
            end else begin
              unique case (dec.kind)
                scta_pkg::KIND_SHIFT: begin
                  shift_flag <= !shift_flag;
                  state      <= ST_FINISH;
                end
                scta_pkg::KIND_BKSP: begin
                  if (count != '0) begin
                    count  <= count - 1'b1;
                    wr_idx <= wr_idx_dec;
                  end
                  state <= ST_FINISH;
                end
                scta_pkg::KIND_TAB: begin
                  remain <= TW'(TAB_SPACES - 1);
                  state  <= ST_WRITE;
                end
                scta_pkg::KIND_ENTER, scta_pkg::KIND_SPACE, scta_pkg::KIND_KEY: begin
                  remain <= '0;
                  state  <= ST_WRITE;
                end
                default: begin
                  state <= ST_FINISH;
                end
              endcase
            end
          end
        end
        ST_WRITE: begin
          entry_valid[wr_idx] <= 1'b1;
          if (op_kind == scta_pkg::KIND_ENTER) begin
            count  <= '0;
            wr_idx <= '0;
            rd_idx <= '0;
            state  <= ST_FINISH;
          end else begin
            wr_idx <= wr_idx_inc;
            if (count < FullCnt) begin
              count <= count + 1'b1;
            end else if (op_kind == scta_pkg::KIND_KEY) begin
              count <= CW'(1);
            end
            if (remain == '0) begin
              state <= ST_FINISH;
            end else begin
              remain <= remain - 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      read_char  <= (op_read && rd_hit) ? rdata : 8'h00;
      line_done  <= !op_read && (op_kind == scta_pkg::KIND_ENTER);
      fill_count <= 6'(count);
      shift_on   <= shift_flag;
    end
  end

`ifndef SYNTHESIS
  // The character count never runs past the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt)
    else $error("character count exceeds buffer depth");

  // A finished line leaves an empty buffer.
  a_enter_empties: assert property (@(posedge clk) disable iff (rst)
    (res_valid && line_done) |-> (fill_count == 6'd0))
    else $error("line_done with nonzero fill count");

  // Only one transaction is in the block at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd_ready)
    else $error("second transaction accepted while one is in progress");

  // Memory writes only come from character-storing operations.
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (!op_read && (op_kind == scta_pkg::KIND_TAB ||
                op_kind == scta_pkg::KIND_ENTER || op_kind == scta_pkg::KIND_SPACE ||
                op_kind == scta_pkg::KIND_KEY)))
    else $error("memory write for a non-storing operation");

  // The result register only loads when it is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(read_char) && $stable(fill_count)))
    else $error("pending result overwritten");
`endif

endmodule

// ----- sim/tb_scancode_to_ascii_line_buffer_core.sv -----
// Self-checking testbench for the scancode-to-ASCII line buffer core.
// Uses scta_pkg for the scan code constants; a local line buffer predictor checks
// every result against its own copy of the buffer state, but for typed directed rows.
module tb_scancode_to_ascii_line_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BufDepth   = 32;
  localparam int TabSpaces  = 8;
  localparam int KeyCount   = 47;
  localparam int ItemTarget = 1600;
  localparam int QuietAfter = 1400;
  localparam int CycleLimit = 400000;

  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic [7:0] ch;
    logic       done;
    logic [5:0] count;
    logic       shift;
  } line_result_t;

  // One row of the directed stimulus; typed rows carry a hand-written result.
  typedef struct packed {
    logic         f;
    logic [7:0]   code;
    logic         typed;
    line_result_t want;
  } stim_row_t;

  localparam line_result_t NO_WANT = '0;
  localparam int DirectedRows = 23;

  // Make codes of the table keys and the two characters each one produces.
  logic [7:0] key_make [0:KeyCount-1] = '{
    8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d,
    8'h15, 8'h2c, 8'h29, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h1a, 8'h1b, 8'h27, 8'h28, 8'h2b, 8'h33, 8'h34, 8'h35};
  logic [7:0] key_plain [0:KeyCount-1] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c,
    8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7a, 8'h60, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h30, 8'h2d, 8'h3d, 8'h5b, 8'h5d, 8'h3b, 8'h27, 8'h5c, 8'h2c, 8'h2e, 8'h2f};
  logic [7:0] key_upper [0:KeyCount-1] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c,
    8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5a, 8'h7e, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28,
    8'h29, 8'h5f, 8'h2b, 8'h7b, 8'h7d, 8'h3a, 8'h22, 8'h7c, 8'h3c, 8'h3e, 8'h3f};

  // Directed stimulus: reset state, empty backspace, ignored codes, every shift code,
  // the two odd shifted keys, tab, space, reads, enter and a read after enter.
  stim_row_t directed_rows [0:DirectedRows-1] = '{
    '{FUNC_READ, 8'hff, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0}},
    '{FUNC_SCAN, scta_pkg::SC_BACKSPACE, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0}},
    '{FUNC_SCAN, 8'h00, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0}},
    '{FUNC_SCAN, 8'hff, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0}},
    '{FUNC_SCAN, 8'h1e, 1'b1, '{8'h00, 1'b0, 6'd1, 1'b0}},
    '{FUNC_SCAN, scta_pkg::SC_CAPS_MAKE, 1'b1, '{8'h00, 1'b0, 6'd1, 1'b1}},
    '{FUNC_SCAN, 8'h29, 1'b0, NO_WANT},
    '{FUNC_SCAN, 8'h0a, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_LSHIFT_MAKE, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_RSHIFT_MAKE, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_LSHIFT_BREAK, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_RSHIFT_BREAK, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_TAB, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_SPACE, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_BACKSPACE, 1'b0, NO_WANT},
    '{FUNC_SCAN, 8'h9e, 1'b0, NO_WANT},
    '{FUNC_SCAN, 8'h35, 1'b0, NO_WANT},
    '{FUNC_READ, 8'h00, 1'b0, NO_WANT},
    '{FUNC_READ, 8'haa, 1'b0, NO_WANT},
    '{FUNC_SCAN, scta_pkg::SC_ENTER, 1'b1, '{8'h00, 1'b1, 6'd0, 1'b1}},
    '{FUNC_READ, 8'h55, 1'b0, NO_WANT},
    '{FUNC_SCAN, 8'h02, 1'b0, NO_WANT},
    '{FUNC_SCAN, 8'h80, 1'b0, NO_WANT}};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  logic       func = 1'b0;
  logic [7:0] scan_code = 8'h00;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic [7:0] read_char;
  logic       line_done;
  logic [5:0] fill_count;
  logic       shift_on;

  // Predicted buffer state.
  logic       pred_shift;
  logic [7:0] pred_store [0:BufDepth-1];
  logic [4:0] pred_wr;
  logic [4:0] pred_rd;
  logic [5:0] pred_count;

  line_result_t pending_results [$];
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int lines_ended = 0;
  int full_hits = 0;
  int cycle_count = 0;
  int sink_stall = 0;
  logic sender_idle_ok = 1'b0;
  logic sink_idle_ok = 1'b0;

  scancode_to_ascii_line_buffer_core u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .func(func),
    .scan_code(scan_code),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .read_char(read_char),
    .line_done(line_done),
    .fill_count(fill_count),
    .shift_on(shift_on)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Writes one character into the predicted ring; table keys restart a full count.
  function automatic void store_char(input logic [7:0] ch, input bit restart_when_full);
    pred_store[pred_wr] = ch;
    pred_wr = pred_wr + 5'd1;
    if (pred_count < BufDepth) begin
      pred_count = pred_count + 6'd1;
    end else if (restart_when_full) begin
      pred_count = 6'd1;
    end
    if (pred_count == BufDepth) begin
      full_hits++;
    end
  endfunction

  // Applies one transaction to the predicted state and returns the result it causes.
  function automatic line_result_t step_line_buffer(input logic f, input logic [7:0] code);
    line_result_t r;
    r = '0;
    if (f == FUNC_READ) begin
      r.ch = pred_store[pred_rd];
      pred_rd = pred_rd + 5'd1;
    end else if (code == scta_pkg::SC_CAPS_MAKE || code == scta_pkg::SC_LSHIFT_MAKE ||
                 code == scta_pkg::SC_RSHIFT_MAKE || code == scta_pkg::SC_LSHIFT_BREAK ||
                 code == scta_pkg::SC_RSHIFT_BREAK) begin
      pred_shift = ~pred_shift;
    end else if (code == scta_pkg::SC_BACKSPACE) begin
      if (pred_count != 0) begin
        pred_count = pred_count - 6'd1;
        pred_wr = pred_wr - 5'd1;
      end
    end else if (code == scta_pkg::SC_TAB) begin
      for (int i = 0; i < TabSpaces; i++) begin
        store_char(scta_pkg::CH_SPACE, 1'b0);
      end
    end else if (code == scta_pkg::SC_ENTER) begin
      pred_store[pred_wr] = scta_pkg::CH_CR;
      pred_count = '0;
      pred_wr = '0;
      pred_rd = '0;
      r.done = 1'b1;
    end else if (code == scta_pkg::SC_SPACE) begin
      store_char(scta_pkg::CH_SPACE, 1'b0);
    end else begin
      for (int i = 0; i < KeyCount; i++) begin
        if (key_make[i] == code) begin
          store_char(pred_shift ? key_upper[i] : key_plain[i], 1'b1);
          break;
        end
      end
    end
    r.count = pred_count;
    r.shift = pred_shift;
    return r;
  endfunction

  // Offers one transaction, waits for acceptance, records its expected result and
  // sometimes leaves a gap before the next one.
  task automatic send_cmd(input logic f, input logic [7:0] code, input logic typed,
                          input line_result_t want);
    line_result_t predicted;
    cmd_valid <= 1'b1;
    func <= f;
    scan_code <= code;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predicted = step_line_buffer(f, code);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (predicted.done) begin
      lines_ended++;
    end
    if (sender_idle_ok && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Holds off new transactions until every outstanding result has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One random keystroke of a typed line, weighted toward table keys.
  task automatic send_keystroke();
    int pick;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      code = key_make[$urandom_range(0, KeyCount - 1)];
      if ($urandom_range(0, 9) == 0) begin
        code = code | 8'h80;
      end
    end else if (pick < 72) begin
      case ($urandom_range(0, 4))
        0: code = scta_pkg::SC_CAPS_MAKE;
        1: code = scta_pkg::SC_LSHIFT_MAKE;
        2: code = scta_pkg::SC_RSHIFT_MAKE;
        3: code = scta_pkg::SC_LSHIFT_BREAK;
        default: code = scta_pkg::SC_RSHIFT_BREAK;
      endcase
    end else if (pick < 79) begin
      code = scta_pkg::SC_BACKSPACE;
    end else if (pick < 83) begin
      code = scta_pkg::SC_TAB;
    end else if (pick < 90) begin
      code = scta_pkg::SC_SPACE;
    end else begin
      send_cmd(FUNC_READ, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
      return;
    end
    send_cmd(FUNC_SCAN, code, 1'b0, NO_WANT);
  endtask

  // Result side: random stall bursts while idling is allowed.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b1;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      res_ready <= 1'b0;
    end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 6);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    line_result_t exp_res;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transaction: read_char=%02h line_done=%0d",
                 $time, read_char, line_done);
        $display("%0t: unexpected result transaction: fill_count=%0d shift_on=%0d",
                 $time, fill_count, shift_on);
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (read_char !== exp_res.ch) begin
          error_count++;
          $display("%0t: read_char expected %02h actual %02h", $time, exp_res.ch, read_char);
        end
        if (line_done !== exp_res.done) begin
          error_count++;
          $display("%0t: line_done expected %0d actual %0d", $time, exp_res.done, line_done);
        end
        if (fill_count !== exp_res.count) begin
          error_count++;
          $display("%0t: fill_count expected %0d actual %0d", $time, exp_res.count, fill_count);
        end
        if (shift_on !== exp_res.shift) begin
          error_count++;
          $display("%0t: shift_on expected %0d actual %0d", $time, exp_res.shift, shift_on);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_scancode_to_ascii_line_buffer_core: errors");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random lines, noise and read bursts.
  initial begin
    int line_len;
    pred_shift = 1'b0;
    pred_wr = '0;
    pred_rd = '0;
    pred_count = '0;
    for (int i = 0; i < BufDepth; i++) begin
      pred_store[i] = 8'h00;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirectedRows; i++) begin
      send_cmd(directed_rows[i].f, directed_rows[i].code, directed_rows[i].typed,
               directed_rows[i].want);
    end
    drain_results();

    while (items_sent < ItemTarget) begin
      // Idling mode changes per segment; the tail of the run has none.
      if (items_sent >= QuietAfter) begin
        sender_idle_ok <= 1'b0;
        sink_idle_ok <= 1'b0;
      end else begin
        sender_idle_ok <= ($urandom_range(0, 3) != 0);
        sink_idle_ok <= ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          // A typed line, usually ended by enter and followed by a few reads.
          line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 50) : $urandom_range(0, 20);
          for (int k = 0; k < line_len; k++) begin
            send_keystroke();
          end
          if ($urandom_range(0, 7) != 0) begin
            send_cmd(FUNC_SCAN, scta_pkg::SC_ENTER, 1'b0, NO_WANT);
          end
          repeat ($urandom_range(1, 3)) begin
            send_cmd(FUNC_READ, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
          end
        end
        7: begin
          // Unstructured noise over both fields.
          repeat ($urandom_range(1, 10)) begin
            send_cmd(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
          end
        end
        8: begin
          // Read burst, at times long enough to wrap the read index.
          repeat ($urandom_range(1, 40)) begin
            send_cmd(FUNC_READ, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
          end
        end
        default: begin
          drain_results();
        end
      endcase
    end

    drain_results();
    repeat (TabSpaces + 8) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results, %0d lines ended by enter,",
             items_sent, results_checked, lines_ended);
    $display("buffer reached full depth %0d times; %0d mismatches.", full_hits, error_count);
    if (error_count == 0) begin
      $display("tb_scancode_to_ascii_line_buffer_core: clean");
    end else begin
      $display("tb_scancode_to_ascii_line_buffer_core: errors");
    end
    $finish;
  end

endmodule
